// ===== rtl/ilp_pkg.sv =====
`timescale 1ns / 1ps

package ilp_pkg;

  localparam int CHAR_W = 8;
  localparam int MAG_W  = 64;
  localparam int STAT_W = 3;

  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SIGNED = 2'd1;
  localparam logic [1:0] PH_ZERO   = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_HEX = 2'd1;
  localparam logic [1:0] RX_BIN = 2'd2;
  localparam logic [1:0] RX_OCT = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_INVALID    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NEG_RANGE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_ESCAPE = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_CHAR   = 3'd4;

  localparam logic [MAG_W-1:0] MIN_MAGNITUDE = {1'b1, {(MAG_W-1){1'b0}}};

  // Finished token state, handed from the accumulator to the result stage
  typedef struct packed {
    logic              char_lit;
    logic              len3;
    logic              len4;
    logic [7:0]        second_byte;
    logic [7:0]        third_byte;
    logic              zero_only;
    logic              invalid;
    logic              digit_seen;
    logic              negative;
    logic [MAG_W-1:0]  magnitude;
  } snap_t;

  // {ok, byte} for the character after a backslash
  function automatic logic [8:0] escape_lookup(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h30:     r = {1'b1, 8'd0};
      8'h6e:     r = {1'b1, 8'd10};
      8'h72:     r = {1'b1, 8'd13};
      8'h74:     r = {1'b1, 8'd9};
      CH_BSLASH: r = {1'b1, 8'd92};
      CH_QUOTE:  r = {1'b1, 8'd39};
      default:   r = {1'b0, 8'd0};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ilp_accum.sv =====
`timescale 1ns / 1ps

module ilp_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic                        last,
  input  logic [ilp_pkg::CHAR_W-1:0]  char_in,
  input  logic                        snap_pop,
  output logic                        snap_valid,
  output ilp_pkg::snap_t              snap
);

  logic [2:0]                 count_r, count_nxt;
  logic [7:0]                 first_r, first_nxt;
  logic [7:0]                 second_r, second_nxt;
  logic [7:0]                 third_r, third_nxt;
  logic                       neg_r, neg_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic [1:0]                 radix_r, radix_nxt;
  logic [ilp_pkg::MAG_W-1:0]  mag_r, mag_nxt;
  logic                       inval_r, inval_nxt;
  logic                       seen_r, seen_nxt;
  logic                       snap_valid_r;
  ilp_pkg::snap_t             snap_r, snap_nxt;

  logic                       dig_en;
  logic                       dok;
  logic [7:0]                 dfull;
  logic [5:0]                 d;
  logic [5:0]                 dlim;
  logic                       dvalid;
  logic [ilp_pkg::MAG_W+3:0]  prod;
  logic [ilp_pkg::MAG_W+3:0]  sum;

  always_comb begin
    dok   = 1'b1;
    dfull = 8'd0;
    if (char_in >= 8'h30 && char_in <= 8'h39) begin
      dfull = char_in - 8'h30;
    end else if (char_in >= 8'h61 && char_in <= 8'h7a) begin
      dfull = char_in - 8'd87;
    end else if (char_in >= 8'h41 && char_in <= 8'h5a) begin
      dfull = char_in - 8'd55;
    end else begin
      dok = 1'b0;
    end
    d = dfull[5:0];
    case (radix_r)
      ilp_pkg::RX_HEX: dlim = 6'd16;
      ilp_pkg::RX_BIN: dlim = 6'd2;
      ilp_pkg::RX_OCT: dlim = 6'd8;
      default:         dlim = 6'd10;
    endcase
    dvalid = dok && (d < dlim);
  end

  // shift-add multiply by the radix, plus the digit; top four bits flag overflow
  always_comb begin
    case (radix_r)
      ilp_pkg::RX_HEX: prod = {mag_r, 4'b0};
      ilp_pkg::RX_BIN: prod = {3'b0, mag_r, 1'b0};
      ilp_pkg::RX_OCT: prod = {1'b0, mag_r, 3'b0};
      default:         prod = {1'b0, mag_r, 3'b0} + {3'b0, mag_r, 1'b0};
    endcase
    sum = prod + {{(ilp_pkg::MAG_W-2){1'b0}}, d};
  end

  always_comb begin
    count_nxt  = (count_r < 3'd7) ? count_r + 3'd1 : count_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    third_nxt  = third_r;
    neg_nxt    = neg_r;
    phase_nxt  = phase_r;
    radix_nxt  = radix_r;
    mag_nxt    = mag_r;
    inval_nxt  = inval_r;
    seen_nxt   = seen_r;
    dig_en     = 1'b0;

    if (count_r == 3'd0) first_nxt = char_in;
    if (count_r == 3'd1) second_nxt = char_in;
    if (count_r == 3'd2) third_nxt = char_in;

    case (phase_r)
      ilp_pkg::PH_START: begin
        if (char_in == 8'h2b || char_in == 8'h2d) begin
          neg_nxt   = (char_in == 8'h2d);
          phase_nxt = ilp_pkg::PH_SIGNED;
        end else if (char_in == 8'h30) begin
          phase_nxt = ilp_pkg::PH_ZERO;
        end else begin
          phase_nxt = ilp_pkg::PH_DIGITS;
          dig_en    = 1'b1;
        end
      end
      ilp_pkg::PH_SIGNED: begin
        if (char_in == 8'h30) begin
          phase_nxt = ilp_pkg::PH_ZERO;
        end else begin
          phase_nxt = ilp_pkg::PH_DIGITS;
          dig_en    = 1'b1;
        end
      end
      ilp_pkg::PH_ZERO: begin
        phase_nxt = ilp_pkg::PH_DIGITS;
        if (char_in == 8'h78 || char_in == 8'h58) begin
          radix_nxt = ilp_pkg::RX_HEX;
        end else if (char_in == 8'h62 || char_in == 8'h42) begin
          radix_nxt = ilp_pkg::RX_BIN;
        end else if (char_in == 8'h6f || char_in == 8'h4f) begin
          radix_nxt = ilp_pkg::RX_OCT;
        end else begin
          seen_nxt = 1'b1;
          dig_en   = 1'b1;
        end
      end
      default: begin
        dig_en = 1'b1;
      end
    endcase

    if (dig_en) begin
      if (!dvalid) begin
        inval_nxt = 1'b1;
      end else begin
        seen_nxt = 1'b1;
        if (!inval_r) begin
          if (|sum[ilp_pkg::MAG_W+3:ilp_pkg::MAG_W]) begin
            inval_nxt = 1'b1;
          end else begin
            mag_nxt = sum[ilp_pkg::MAG_W-1:0];
          end
        end
      end
    end

    snap_nxt.char_lit    = (count_r >= 3'd2) && (first_nxt == ilp_pkg::CH_QUOTE) &&
                           (char_in == ilp_pkg::CH_QUOTE);
    snap_nxt.len3        = (count_r == 3'd2);
    snap_nxt.len4        = (count_r == 3'd3);
    snap_nxt.second_byte = second_nxt;
    snap_nxt.third_byte  = third_nxt;
    snap_nxt.zero_only   = (phase_nxt == ilp_pkg::PH_ZERO);
    snap_nxt.invalid     = inval_nxt;
    snap_nxt.digit_seen  = seen_nxt;
    snap_nxt.negative    = neg_nxt;
    snap_nxt.magnitude   = mag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 3'd0;
      first_r  <= 8'd0;
      second_r <= 8'd0;
      third_r  <= 8'd0;
      neg_r    <= 1'b0;
      phase_r  <= ilp_pkg::PH_START;
      radix_r  <= ilp_pkg::RX_DEC;
      mag_r    <= '0;
      inval_r  <= 1'b0;
      seen_r   <= 1'b0;
    end else if (take) begin
      if (last) begin
        count_r  <= 3'd0;
        first_r  <= 8'd0;
        second_r <= 8'd0;
        third_r  <= 8'd0;
        neg_r    <= 1'b0;
        phase_r  <= ilp_pkg::PH_START;
        radix_r  <= ilp_pkg::RX_DEC;
        mag_r    <= '0;
        inval_r  <= 1'b0;
        seen_r   <= 1'b0;
      end else begin
        count_r  <= count_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
        third_r  <= third_nxt;
        neg_r    <= neg_nxt;
        phase_r  <= phase_nxt;
        radix_r  <= radix_nxt;
        mag_r    <= mag_nxt;
        inval_r  <= inval_nxt;
        seen_r   <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (take && last) begin
      snap_valid_r <= 1'b1;
    end else if (snap_pop) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    take && last |=> count_r == 3'd0 && phase_r == ilp_pkg::PH_START && !inval_r)
    else $error("token state not cleared after last character");
`endif

endmodule

// ===== rtl/ilp_final.sv =====
`timescale 1ns / 1ps

module ilp_final (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         snap_valid,
  input  ilp_pkg::snap_t               snap,
  input  logic                         out_ready,
  output logic                         snap_pop,
  output logic                         out_valid,
  output logic [ilp_pkg::MAG_W-1:0]    value,
  output logic [ilp_pkg::STAT_W-1:0]   status
);

  logic                        out_free;
  logic                        load;
  logic                        out_valid_r;
  logic [ilp_pkg::MAG_W-1:0]   value_r, value_nxt;
  logic [ilp_pkg::STAT_W-1:0]  status_r, status_nxt;
  logic [8:0]                  esc;

  assign out_free = !out_valid_r || out_ready;
  assign load     = snap_valid && out_free;
  assign snap_pop = out_free;

  always_comb begin
    esc        = ilp_pkg::escape_lookup(snap.third_byte);
    value_nxt  = '0;
    status_nxt = ilp_pkg::ST_OK;
    if (snap.char_lit) begin
      if (snap.len3) begin
        value_nxt = {{(ilp_pkg::MAG_W-8){1'b0}}, snap.second_byte};
      end else if (snap.len4 && snap.second_byte == ilp_pkg::CH_BSLASH) begin
        if (esc[8]) begin
          value_nxt = {{(ilp_pkg::MAG_W-8){1'b0}}, esc[7:0]};
        end else begin
          status_nxt = ilp_pkg::ST_BAD_ESCAPE;
        end
      end else begin
        status_nxt = ilp_pkg::ST_BAD_CHAR;
      end
    end else if (snap.zero_only) begin
      value_nxt = '0;
    end else if (snap.invalid || !snap.digit_seen) begin
      status_nxt = ilp_pkg::ST_INVALID;
    end else if (snap.negative) begin
      if (snap.magnitude > ilp_pkg::MIN_MAGNITUDE) begin
        status_nxt = ilp_pkg::ST_NEG_RANGE;
      end else begin
        value_nxt = ~snap.magnitude + {{(ilp_pkg::MAG_W-1){1'b0}}, 1'b1};
      end
    end else begin
      value_nxt = snap.magnitude;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign value     = value_r;
  assign status    = status_r;

endmodule

// ===== rtl/integer_literal_parser.sv =====
`timescale 1ns / 1ps

// Parses one operand token, one character per transfer with tlast on the final
// character, into a signed 64-bit value and a status (0 ok, 1 invalid number,
// 2 negative out of range, 3 bad escape, 4 bad character literal). Takes one
// character every cycle, the rate set by the shift-add digit accumulator, but
// holds a last character while the previous token's snapshot still waits for a
// stalled result register. A token's last character passes from the input
// register to the accumulator snapshot, then to the result register.

module integer_literal_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [63:0] value, [66:64] status, [71:67] zero
);

  logic                        in_valid_r;
  logic [ilp_pkg::CHAR_W-1:0]  char_r;
  logic                        last_r;
  logic                        take;
  logic                        snap_valid;
  logic                        snap_pop;
  ilp_pkg::snap_t              snap;
  logic [ilp_pkg::MAG_W-1:0]   value;
  logic [ilp_pkg::STAT_W-1:0]  status;

  assign take      = in_valid_r && (!last_r || !snap_valid || snap_pop);
  assign in_tready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  ilp_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .last       (last_r),
    .char_in    (char_r),
    .snap_pop   (snap_pop),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  ilp_final u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_valid (snap_valid),
    .snap       (snap),
    .out_ready  (out_tready),
    .snap_pop   (snap_pop),
    .out_valid  (out_tvalid),
    .value      (value),
    .status     (status)
  );

  assign out_tdata = {5'b0, status, value};

`ifndef SYNTHESIS
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66:64] != ilp_pkg::ST_OK |-> out_tdata[63:0] == 64'd0)
    else $error("nonzero value with error status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[66:64] <= ilp_pkg::ST_BAD_CHAR)
    else $error("undefined status code");

  a_idle_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid && !snap_valid)
    else $error("result pending right after reset");
`endif

endmodule

// ===== tb/tb_integer_literal_parser.sv =====
`timescale 1ns / 1ps

module tb_integer_literal_parser;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_CHARS_PER_PHASE = 420;

  typedef struct packed {
    logic [63:0]                value;
    logic [ilp_pkg::STAT_W-1:0] status;
  } lit_result_t;

  class literal_scoreboard;
    logic [2:0]        char_count;
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic [7:0]        byte2;
    logic              neg;
    logic [1:0]        phase;
    logic [1:0]        radix;
    logic [63:0]       mag;
    logic              bad;
    logic              seen;
    lit_result_t       expected_results[$];
    int unsigned       errors;

    function void clear_token();
      char_count = 0;
      byte0 = 0;
      byte1 = 0;
      byte2 = 0;
      neg = 0;
      phase = ilp_pkg::PH_START;
      radix = ilp_pkg::RX_DEC;
      mag = 0;
      bad = 0;
      seen = 0;
    endfunction

    function new();
      errors = 0;
      clear_token();
    endfunction

    function void add_digit(logic [7:0] c);
      logic [63:0] d;
      logic [63:0] base;
      case (radix)
        ilp_pkg::RX_HEX: base = 64'd16;
        ilp_pkg::RX_BIN: base = 64'd2;
        ilp_pkg::RX_OCT: base = 64'd8;
        default:         base = 64'd10;
      endcase
      if (c >= "0" && c <= "9") d = 64'(c) - 64'(8'h30);
      else if (c >= "a" && c <= "z") d = 64'(c) - 64'(8'h61) + 64'd10;
      else if (c >= "A" && c <= "Z") d = 64'(c) - 64'(8'h41) + 64'd10;
      else begin
        bad = 1;
        return;
      end
      if (d >= base) begin
        bad = 1;
        return;
      end
      seen = 1;
      if (bad) return;
      if (mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / base) begin
        bad = 1;
        return;
      end
      mag = mag * base + d;
    endfunction

    function void number_byte(logic [7:0] c);
      case (phase)
        ilp_pkg::PH_START, ilp_pkg::PH_SIGNED: begin
          if (phase == ilp_pkg::PH_START && (c == "+" || c == "-")) begin
            neg = (c == "-");
            phase = ilp_pkg::PH_SIGNED;
          end else if (c == "0") begin
            phase = ilp_pkg::PH_ZERO;
          end else begin
            phase = ilp_pkg::PH_DIGITS;
            add_digit(c);
          end
        end
        ilp_pkg::PH_ZERO: begin
          phase = ilp_pkg::PH_DIGITS;
          if (c == "x" || c == "X") radix = ilp_pkg::RX_HEX;
          else if (c == "b" || c == "B") radix = ilp_pkg::RX_BIN;
          else if (c == "o" || c == "O") radix = ilp_pkg::RX_OCT;
          else begin
            seen = 1;
            add_digit(c);
          end
        end
        default: add_digit(c);
      endcase
    endfunction

    function void note_char(logic [7:0] c, logic l);
      logic [3:0]  len;
      lit_result_t r;
      if (char_count == 0) byte0 = c;
      else if (char_count == 1) byte1 = c;
      else if (char_count == 2) byte2 = c;
      number_byte(c);
      len = {1'b0, char_count} + 4'd1;
      if (char_count < 3'd7) char_count++;
      if (!l) return;
      r.value = 0;
      r.status = ilp_pkg::ST_OK;
      if (len >= 4'd3 && byte0 == ilp_pkg::CH_QUOTE && c == ilp_pkg::CH_QUOTE) begin
        if (len == 4'd3) begin
          r.value = {56'd0, byte1};
        end else if (len == 4'd4 && byte1 == ilp_pkg::CH_BSLASH) begin
          case (byte2)
            "0":               r.value = 64'd0;
            "n":               r.value = 64'd10;
            "r":               r.value = 64'd13;
            "t":               r.value = 64'd9;
            ilp_pkg::CH_BSLASH: r.value = 64'd92;
            ilp_pkg::CH_QUOTE:  r.value = 64'd39;
            default:           r.status = ilp_pkg::ST_BAD_ESCAPE;
          endcase
        end else begin
          r.status = ilp_pkg::ST_BAD_CHAR;
        end
      end else if (phase == ilp_pkg::PH_ZERO) begin
        r.value = 0;
      end else if (bad || !seen) begin
        r.status = ilp_pkg::ST_INVALID;
      end else if (neg) begin
        if (mag > ilp_pkg::MIN_MAGNITUDE) r.status = ilp_pkg::ST_NEG_RANGE;
        else r.value = 64'd0 - mag;
      end else begin
        r.value = mag;
      end
      if (r.status != ilp_pkg::ST_OK) r.value = 0;
      expected_results.insert(expected_results.size(), r);
      clear_token();
    endfunction

    function void check_result(logic [63:0] v, logic [ilp_pkg::STAT_W-1:0] s);
      lit_result_t exp_r;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h status=%0d", $time, v, s);
        return;
      end
      exp_r = expected_results.pop_front();
      if (v !== exp_r.value) begin
        errors++;
        $display("%0t: value mismatch expected=%h actual=%h", $time, exp_r.value, v);
      end
      if (s !== exp_r.status) begin
        errors++;
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, exp_r.status, s);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  token_q[$];

  literal_scoreboard sb = new();

  integer_literal_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata[63:0], out_tdata[66:64]);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_char(logic [7:0] c, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_token();
    for (int i = 0; i < token_q.size(); i++) send_char(token_q[i], i == token_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.expected_results.size() != 0);
  endtask

  function automatic logic [7:0] digit_char(int unsigned d);
    if (d < 10) return 8'(8'h30 + d);
    return 8'(($urandom_range(1) ? 8'h41 : 8'h61) + d - 10);
  endfunction

  task automatic append_byte(logic [7:0] c);
    token_q.insert(token_q.size(), c);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic push_prefix(int unsigned base);
    append_byte("0");
    case (base)
      16:      append_byte($urandom_range(1) ? "x" : "X");
      2:       append_byte($urandom_range(1) ? "b" : "B");
      8:       append_byte($urandom_range(1) ? "o" : "O");
      default: append_byte("0");
    endcase
  endtask

  task automatic push_value(logic [63:0] v, int unsigned base);
    logic [7:0] digs[$];
    if (v == 0) digs.push_front("0");
    while (v != 0) begin
      digs.push_front(digit_char(int'(v % 64'(base))));
      v = v / 64'(base);
    end
    foreach (digs[i]) append_byte(digs[i]);
  endtask

  task automatic build_number();
    int unsigned base;
    int unsigned kind;
    int unsigned ndig;
    int unsigned maxd;
    logic [63:0] v;
    case ($urandom_range(2))
      1: append_byte("+");
      2: append_byte("-");
      default: ;
    endcase
    case ($urandom_range(3))
      0: base = 10;
      1: base = 16;
      2: base = 2;
      default: base = 8;
    endcase
    if (base != 10) push_prefix(base);
    kind = $urandom_range(99);
    if (kind < 60) begin
      ndig = (kind < 4) ? 0 : $urandom_range(1, 6);
      repeat (ndig) append_byte(digit_char($urandom_range(base - 1)));
    end else if (kind < 88) begin
      case ($urandom_range(6))
        0: v = 64'h7FFF_FFFF_FFFF_FFFF;
        1: v = 64'h8000_0000_0000_0000;
        2: v = 64'h8000_0000_0000_0001;
        3: v = 64'hFFFF_FFFF_FFFF_FFFF;
        4: v = 64'hFFFF_FFFF_FFFF_FFFE;
        5: v = {$urandom, $urandom};
        default: v = 64'($urandom_range(1000));
      endcase
      push_value(v, base);
    end else begin
      case (base)
        2:  maxd = 64;
        8:  maxd = 22;
        16: maxd = 16;
        default: maxd = 20;
      endcase
      ndig = maxd - 1 + $urandom_range(2);
      append_byte(digit_char($urandom_range(1, base - 1)));
      repeat (ndig - 1) append_byte(digit_char($urandom_range(base - 1)));
    end
    if ($urandom_range(99) < 8)
      token_q.insert($urandom_range(token_q.size()), 8'($urandom_range(255)));
    if (token_q.size() == 0) append_byte("0");
  endtask

  task automatic build_char_literal();
    int unsigned k;
    string esc_chars;
    esc_chars = "0nrt\\'";
    k = $urandom_range(9);
    append_byte(ilp_pkg::CH_QUOTE);
    if (k < 4) begin
      append_byte(8'($urandom_range(255)));
      append_byte(ilp_pkg::CH_QUOTE);
    end else if (k < 7) begin
      append_byte(ilp_pkg::CH_BSLASH);
      if ($urandom_range(1)) append_byte(esc_chars[$urandom_range(5)]);
      else append_byte(8'($urandom_range(255)));
      append_byte(ilp_pkg::CH_QUOTE);
    end else if (k == 7) begin
      repeat ($urandom_range(2, 5)) append_byte(8'($urandom_range(255)));
      append_byte(ilp_pkg::CH_QUOTE);
    end else if (k == 8) begin
      repeat ($urandom_range(2)) append_byte(8'($urandom_range(255)));
    end else begin
      repeat (2) append_byte(8'($urandom_range(255)));
      append_byte(ilp_pkg::CH_QUOTE);
    end
  endtask

  task automatic build_random_token();
    int unsigned k;
    token_q.delete();
    k = $urandom_range(99);
    if (k < 58) build_number();
    else if (k < 80) build_char_literal();
    else repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(255)));
  endtask

  task automatic run_random(int unsigned n_chars);
    int unsigned sent;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < n_chars) begin
      build_random_token();
      send_token();
      sent += token_q.size();
      if (!paused && sent >= n_chars / 2) begin
        paused = 1;
        wait_drained();
      end
    end
  endtask

  initial begin
    string lits[];
    lits = '{"0", "+0", "-0", "7", "'A'", "'\\n'", "'\\0'", "'\\r'", "'\\t'",
             "'\\\\'", "'\\''", "'\\q'", "'ab'", "'abcd'", "'a", "''", "-",
             "0x", "-0b", "0x1g", "+-5", "0o17", "0B101", "0x8000000000000000",
             "0xffffffffffffffff", "0x10000000000000000", "-0x8000000000000000",
             "-0x8000000000000001", "18446744073709551616", "-9223372036854775808"};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (lits[i]) begin
      token_q.delete();
      push_text(lits[i]);
      send_token();
    end
    token_q = '{ilp_pkg::CH_QUOTE, 8'h00, ilp_pkg::CH_QUOTE};
    send_token();
    token_q = '{ilp_pkg::CH_QUOTE, 8'hFF, ilp_pkg::CH_QUOTE};
    send_token();
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      run_random(RANDOM_CHARS_PER_PHASE);
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
